>>> hdl/jct_pkg.sv
// shared types and defaults of the jpeg 2000 component transform
package jct_pkg;

	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int COEF_FRAC_BITS_DEF = 14;

	typedef enum logic [1:0] {
		MODE_RCT_FWD = 2'd0,
		MODE_RCT_INV = 2'd1,
		MODE_ICT_FWD = 2'd2,
		MODE_ICT_INV = 2'd3
	} mode_t;

	typedef struct packed {
		logic  vld;
		logic  line_end;
		mode_t mode;
	} ctl_t;

endpackage

>>> hdl/jct_if.sv
// request channels of the component transform: pixels in, results out, mode write
interface jct_pix_if #(
	parameter int SAMPLE_BITS = jct_pkg::SAMPLE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [SAMPLE_BITS:0]  comp_a;
	logic signed [SAMPLE_BITS:0]  comp_b;
	logic signed [SAMPLE_BITS:0]  comp_c;
	logic                         line_end;

	modport source (output valid, comp_a, comp_b, comp_c, line_end, input ready);
	modport sink   (input valid, comp_a, comp_b, comp_c, line_end, output ready);
endinterface

interface jct_res_if #(
	parameter int SAMPLE_BITS = jct_pkg::SAMPLE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [SAMPLE_BITS:0]  out_a;
	logic signed [SAMPLE_BITS:0]  out_b;
	logic signed [SAMPLE_BITS:0]  out_c;
	logic                         line_end_out;

	modport source (output valid, out_a, out_b, out_c, line_end_out, input ready);
	modport sink   (input valid, out_a, out_b, out_c, line_end_out, output ready);
endinterface

interface jct_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] transform_mode;

	modport source (output valid, transform_mode, input ready);
	modport sink   (input valid, transform_mode, output ready);
endinterface

>>> hdl/jpeg2000_component_transform.sv
// top level of the jpeg 2000 reversible and irreversible color component transform
// Takes one pixel per clock while the output side keeps up, and presents each result
// from the last register stage. The six register stages are: input register,
// first products (luma or inverse coefficients), rounded sums, chroma differences against
// the rounded luma, chroma scaling products, then rounding with saturation. The depth is
// set by the forward irreversible transform, whose chroma products need the rounded luma.
// Each stage holds its own valid bit and takes new data whenever it is empty or the next
// stage moves, so empty slots close up during an output stall and the input stays ready
// until all six stages hold a pixel. Write transform_mode only while no pixel is in flight.
module jpeg2000_component_transform #(
	parameter int SAMPLE_BITS    = jct_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = jct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	jct_pix_if.sink     pix_in,
	jct_res_if.source   res_out,
	jct_cfg_if.sink     cfg
);

	localparam int N  = SAMPLE_BITS + 1;
	localparam int PW = N + COEF_FRAC_BITS + 3;
	localparam int RW = N + 2;

	jct_pkg::mode_t       mode_q;
	jct_pkg::ctl_t        ctl_in, ctl_s1, ctl_s2, ctl_s4, ctl_s6;
	logic signed [N-1:0]  a_s1, b_s1, c_s1;
	logic signed [N-1:0]  a_s2, c_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [RW-1:0] r0_s2, r1_s2, r2_s2;
	logic signed [RW-1:0] r0_s4, r1_s4, r2_s4;
	logic                 vld_s3, vld_s5;
	logic [6:1]           en;
	logic [6:1]           vld;

	// mode register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jct_pkg::MODE_RCT_FWD;
		end else if (cfg.valid) begin
			mode_q <= jct_pkg::mode_t'(cfg.transform_mode);
		end
	end

	// per-stage advance, empty stages fill even while the output stalls
	assign vld   = {ctl_s6.vld, vld_s5, ctl_s4.vld, vld_s3, ctl_s2.vld, ctl_s1.vld};
	assign en[6] = !vld[6] || res_out.ready;
	assign en[5] = !vld[5] || en[6];
	assign en[4] = !vld[4] || en[5];
	assign en[3] = !vld[3] || en[4];
	assign en[2] = !vld[2] || en[3];
	assign en[1] = !vld[1] || en[2];

	assign pix_in.ready = en[1];

	assign ctl_in = '{vld: pix_in.valid, line_end: pix_in.line_end, mode: mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en[1]) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s1 <= pix_in.comp_a;
			b_s1 <= pix_in.comp_b;
			c_s1 <= pix_in.comp_c;
		end
	end

	jct_prod #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_prod (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[2]),
		.ctl_in (ctl_s1),
		.a_in   (a_s1),
		.b_in   (b_s1),
		.c_in   (c_s1),
		.ctl_s2 (ctl_s2),
		.a_s2   (a_s2),
		.c_s2   (c_s2),
		.p0_s2  (p0_s2),
		.p1_s2  (p1_s2),
		.p2_s2  (p2_s2),
		.p3_s2  (p3_s2),
		.r0_s2  (r0_s2),
		.r1_s2  (r1_s2),
		.r2_s2  (r2_s2)
	);

	jct_sum #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.en3    (en[3]),
		.en4    (en[4]),
		.ctl_s2 (ctl_s2),
		.a_s2   (a_s2),
		.c_s2   (c_s2),
		.p0_s2  (p0_s2),
		.p1_s2  (p1_s2),
		.p2_s2  (p2_s2),
		.p3_s2  (p3_s2),
		.r0_s2  (r0_s2),
		.r1_s2  (r1_s2),
		.r2_s2  (r2_s2),
		.vld_s3 (vld_s3),
		.ctl_s4 (ctl_s4),
		.r0_s4  (r0_s4),
		.r1_s4  (r1_s4),
		.r2_s4  (r2_s4)
	);

	jct_chroma #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_chroma (
		.clk    (clk),
		.arst_n (arst_n),
		.en5    (en[5]),
		.en6    (en[6]),
		.ctl_s4 (ctl_s4),
		.r0_s4  (r0_s4),
		.r1_s4  (r1_s4),
		.r2_s4  (r2_s4),
		.vld_s5 (vld_s5),
		.ctl_s6 (ctl_s6),
		.x_s6   (res_out.out_a),
		.y_s6   (res_out.out_b),
		.z_s6   (res_out.out_c)
	);

	assign res_out.valid        = ctl_s6.vld;
	assign res_out.line_end_out = ctl_s6.line_end;

	// a taken request lands in the input stage with the current mode
	a_take_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> ctl_s1.vld && ctl_s1.mode == $past(mode_q))
		else $error("request not captured in input stage");

	// input only stalls when every stage holds a pixel
	a_full_stall : assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> &vld)
		else $error("input stalled with an empty stage");

	// a result held at the output keeps its line end flag
	a_hold_eol : assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid && $stable(ctl_s6))
		else $error("stalled result changed");

endmodule

>>> hdl/jct_prod.sv
// stage 2: first-level coefficient products and the reversible transform
module jct_prod #(
	parameter int SAMPLE_BITS    = jct_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = jct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  jct_pkg::ctl_t                                  ctl_in,
	input  logic signed [SAMPLE_BITS:0]                    a_in,
	input  logic signed [SAMPLE_BITS:0]                    b_in,
	input  logic signed [SAMPLE_BITS:0]                    c_in,
	output jct_pkg::ctl_t                                  ctl_s2,
	output logic signed [SAMPLE_BITS:0]                    a_s2,
	output logic signed [SAMPLE_BITS:0]                    c_s2,
	output logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]   p0_s2,
	output logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]   p1_s2,
	output logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]   p2_s2,
	output logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]   p3_s2,
	output logic signed [SAMPLE_BITS+2:0]                  r0_s2,
	output logic signed [SAMPLE_BITS+2:0]                  r1_s2,
	output logic signed [SAMPLE_BITS+2:0]                  r2_s2
);

	localparam int N  = SAMPLE_BITS + 1;
	localparam int KW = COEF_FRAC_BITS + 3;
	localparam int PW = N + KW;
	localparam int RW = N + 2;

	localparam longint ONE      = longint'(1) << COEF_FRAC_BITS;
	localparam longint K_AR_L   = (299 * ONE * 2 + 1000) / 2000;
	localparam longint K_AG_L   = (587 * ONE * 2 + 1000) / 2000;
	localparam longint K_AB_L   = (114 * ONE * 2 + 1000) / 2000;
	localparam longint K_CB2G_L = (2 * 114 * 886 * ONE * 2 + 587000) / (2 * 587000);
	localparam longint K_CR2G_L = (2 * 299 * 701 * ONE * 2 + 587000) / (2 * 587000);
	localparam longint K_CB2B_L = (1772 * ONE * 2 + 1000) / 2000;
	localparam longint K_CR2R_L = (1402 * ONE * 2 + 1000) / 2000;

	localparam logic signed [KW-1:0] K_AR   = KW'(K_AR_L);
	localparam logic signed [KW-1:0] K_AG   = KW'(K_AG_L);
	localparam logic signed [KW-1:0] K_AB   = KW'(K_AB_L);
	localparam logic signed [KW-1:0] K_CB2G = KW'(K_CB2G_L);
	localparam logic signed [KW-1:0] K_CR2G = KW'(K_CR2G_L);
	localparam logic signed [KW-1:0] K_CB2B = KW'(K_CB2B_L);
	localparam logic signed [KW-1:0] K_CR2R = KW'(K_CR2R_L);

	logic signed [KW-1:0] k0, k1, k2, k3;
	logic signed [N-1:0]  m0, m1, m2, m3;
	logic signed [PW-1:0] pm0, pm1, pm2, pm3;
	logic signed [RW-1:0] ta, tb, tc, g;
	logic signed [RW-1:0] r0, r1, r2;

	always_comb begin
		if (ctl_in.mode == jct_pkg::MODE_ICT_INV) begin
			k0 = K_CR2R; m0 = c_in;
			k1 = K_CR2G; m1 = c_in;
			k2 = K_CB2G; m2 = b_in;
			k3 = K_CB2B; m3 = b_in;
		end else begin
			k0 = K_AR;   m0 = a_in;
			k1 = K_AG;   m1 = b_in;
			k2 = K_AB;   m2 = c_in;
			k3 = '0;     m3 = b_in;
		end
	end

	assign pm0 = PW'(k0) * PW'(m0);
	assign pm1 = PW'(k1) * PW'(m1);
	assign pm2 = PW'(k2) * PW'(m2);
	assign pm3 = PW'(k3) * PW'(m3);

	// reversible transform, exact in RW bits
	assign ta = RW'(a_in);
	assign tb = RW'(b_in);
	assign tc = RW'(c_in);
	assign g  = ta - ((tb + tc) >>> 2);

	always_comb begin
		case (ctl_in.mode)
			jct_pkg::MODE_RCT_FWD: begin
				r0 = (ta + (tb <<< 1) + tc) >>> 2;
				r1 = tc - tb;
				r2 = ta - tb;
			end
			jct_pkg::MODE_RCT_INV: begin
				r0 = tc + g;
				r1 = g;
				r2 = tb + g;
			end
			default: begin
				r0 = '0;
				r1 = '0;
				r2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2  <= a_in;
			c_s2  <= c_in;
			p0_s2 <= pm0;
			p1_s2 <= pm1;
			p2_s2 <= pm2;
			p3_s2 <= pm3;
			r0_s2 <= r0;
			r1_s2 <= r1;
			r2_s2 <= r2;
		end
	end

endmodule

>>> hdl/jct_sum.sv
// stages 3 and 4: rounded product sums for the irreversible modes, then chroma differences against luma for forward ict
module jct_sum #(
	parameter int SAMPLE_BITS    = jct_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = jct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en3,
	input  logic                                           en4,
	input  jct_pkg::ctl_t                                  ctl_s2,
	input  logic signed [SAMPLE_BITS:0]                    a_s2,
	input  logic signed [SAMPLE_BITS:0]                    c_s2,
	input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]   p0_s2,
	input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]   p1_s2,
	input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]   p2_s2,
	input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]   p3_s2,
	input  logic signed [SAMPLE_BITS+2:0]                  r0_s2,
	input  logic signed [SAMPLE_BITS+2:0]                  r1_s2,
	input  logic signed [SAMPLE_BITS+2:0]                  r2_s2,
	output logic                                           vld_s3,
	output jct_pkg::ctl_t                                  ctl_s4,
	output logic signed [SAMPLE_BITS+2:0]                  r0_s4,
	output logic signed [SAMPLE_BITS+2:0]                  r1_s4,
	output logic signed [SAMPLE_BITS+2:0]                  r2_s4
);

	localparam int N  = SAMPLE_BITS + 1;
	localparam int KW = COEF_FRAC_BITS + 3;
	localparam int PW = N + KW;
	localparam int RW = N + 2;
	localparam int SW = PW + 2;

	localparam logic signed [SW-1:0] HALF = SW'(longint'(1) << (COEF_FRAC_BITS - 1));

	logic signed [SW-1:0] ay, sf, sx, sy, sz;
	logic signed [SW-1:0] hf, hx, hy, hz;
	logic signed [RW-1:0] r0, r1, r2;

	jct_pkg::ctl_t        ctl_s3;
	logic signed [N-1:0]  a_s3, c_s3;
	logic signed [RW-1:0] r0_s3, r1_s3, r2_s3;
	logic signed [RW-1:0] d1, d2;

	assign vld_s3 = ctl_s3.vld;

	assign ay = SW'(a_s2) <<< COEF_FRAC_BITS;
	assign sf = SW'(p0_s2) + SW'(p1_s2) + SW'(p2_s2) + HALF;
	assign sx = ay + SW'(p0_s2) + HALF;
	assign sy = ay - SW'(p1_s2) - SW'(p2_s2) + HALF;
	assign sz = ay + SW'(p3_s2) + HALF;

	assign hf = sf >>> COEF_FRAC_BITS;
	assign hx = sx >>> COEF_FRAC_BITS;
	assign hy = sy >>> COEF_FRAC_BITS;
	assign hz = sz >>> COEF_FRAC_BITS;

	always_comb begin
		case (ctl_s2.mode)
			jct_pkg::MODE_ICT_FWD: begin
				r0 = hf[RW-1:0];
				r1 = '0;
				r2 = '0;
			end
			jct_pkg::MODE_ICT_INV: begin
				r0 = hx[RW-1:0];
				r1 = hy[RW-1:0];
				r2 = hz[RW-1:0];
			end
			default: begin
				r0 = r0_s2;
				r1 = r1_s2;
				r2 = r2_s2;
			end
		endcase
	end

	// forward ict: chroma inputs measured from the rounded luma
	assign d1 = (ctl_s3.mode == jct_pkg::MODE_ICT_FWD) ? RW'(c_s3) - r0_s3 : r1_s3;
	assign d2 = (ctl_s3.mode == jct_pkg::MODE_ICT_FWD) ? RW'(a_s3) - r0_s3 : r2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			if (en3) begin
				ctl_s3 <= ctl_s2;
			end
			if (en4) begin
				ctl_s4 <= ctl_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			a_s3  <= a_s2;
			c_s3  <= c_s2;
			r0_s3 <= r0;
			r1_s3 <= r1;
			r2_s3 <= r2;
		end
		if (en4) begin
			r0_s4 <= r0_s3;
			r1_s4 <= d1;
			r2_s4 <= d2;
		end
	end

endmodule

>>> hdl/jct_chroma.sv
// stages 5 and 6: chroma scaling products, rounding and saturation to the sample range
module jct_chroma #(
	parameter int SAMPLE_BITS    = jct_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = jct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en5,
	input  logic                           en6,
	input  jct_pkg::ctl_t                  ctl_s4,
	input  logic signed [SAMPLE_BITS+2:0]  r0_s4,
	input  logic signed [SAMPLE_BITS+2:0]  r1_s4,
	input  logic signed [SAMPLE_BITS+2:0]  r2_s4,
	output logic                           vld_s5,
	output jct_pkg::ctl_t                  ctl_s6,
	output logic signed [SAMPLE_BITS:0]    x_s6,
	output logic signed [SAMPLE_BITS:0]    y_s6,
	output logic signed [SAMPLE_BITS:0]    z_s6
);

	localparam int N  = SAMPLE_BITS + 1;
	localparam int KW = COEF_FRAC_BITS + 3;
	localparam int RW = N + 2;
	localparam int QW = RW + KW;

	localparam longint ONE     = longint'(1) << COEF_FRAC_BITS;
	localparam longint K_BCB_L = (500 * ONE * 2 + 886) / (2 * 886);
	localparam longint K_BCR_L = (500 * ONE * 2 + 701) / (2 * 701);

	localparam logic signed [KW-1:0] K_BCB = KW'(K_BCB_L);
	localparam logic signed [KW-1:0] K_BCR = KW'(K_BCR_L);

	localparam logic signed [QW-1:0] HALF = QW'(longint'(1) << (COEF_FRAC_BITS - 1));
	localparam logic signed [RW-1:0] SMAX = RW'((longint'(1) << (N - 1)) - 1);
	localparam logic signed [RW-1:0] SMIN = RW'(-(longint'(1) << (N - 1)));

	jct_pkg::ctl_t        ctl_s5;
	logic signed [RW-1:0] r0_s5, r1_s5, r2_s5;
	logic signed [QW-1:0] q1_s5, q2_s5;
	logic signed [QW-1:0] q1, q2, h1, h2;
	logic signed [RW-1:0] v0, v1, v2;
	logic signed [N-1:0]  s0, s1, s2;

	assign vld_s5 = ctl_s5.vld;

	assign q1 = QW'(K_BCB) * QW'(r1_s4);
	assign q2 = QW'(K_BCR) * QW'(r2_s4);

	assign h1 = (q1_s5 + HALF) >>> COEF_FRAC_BITS;
	assign h2 = (q2_s5 + HALF) >>> COEF_FRAC_BITS;

	assign v0 = r0_s5;
	assign v1 = (ctl_s5.mode == jct_pkg::MODE_ICT_FWD) ? h1[RW-1:0] : r1_s5;
	assign v2 = (ctl_s5.mode == jct_pkg::MODE_ICT_FWD) ? h2[RW-1:0] : r2_s5;

	assign s0 = (v0 > SMAX) ? SMAX[N-1:0] : ((v0 < SMIN) ? SMIN[N-1:0] : v0[N-1:0]);
	assign s1 = (v1 > SMAX) ? SMAX[N-1:0] : ((v1 < SMIN) ? SMIN[N-1:0] : v1[N-1:0]);
	assign s2 = (v2 > SMAX) ? SMAX[N-1:0] : ((v2 < SMIN) ? SMIN[N-1:0] : v2[N-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			if (en5) begin
				ctl_s5 <= ctl_s4;
			end
			if (en6) begin
				ctl_s6 <= ctl_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			r0_s5 <= r0_s4;
			r1_s5 <= r1_s4;
			r2_s5 <= r2_s4;
			q1_s5 <= q1;
			q2_s5 <= q2;
		end
		if (en6) begin
			x_s6 <= s0;
			y_s6 <= s1;
			z_s6 <= s2;
		end
	end

endmodule
